### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

### rtl/nft_pkg.sv
// ----------------------------------------------------------------------------
// nft_pkg
// Types and constants of the nearest-frequency tuning table.
// ----------------------------------------------------------------------------
package nft_pkg;

    localparam int ANT_W     = 4;
    localparam int FREQ_W    = 30;
    localparam int NET_W     = 32;
    localparam int WIN_W     = 20;
    localparam int DIST_W    = WIN_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 20'd25000;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_ENABLE = 2'd1;

    typedef struct packed {
        logic              command;
        logic [ANT_W-1:0]  antenna;
        logic [FREQ_W-1:0] frequency;
        logic [NET_W-1:0]  network_in;
    } nft_req_t;

    typedef struct packed {
        logic             found;
        logic [NET_W-1:0] network_out;
        logic             table_full;
    } nft_rsp_t;

    typedef struct packed {
        logic [ANT_W-1:0]  antenna;
        logic [FREQ_W-1:0] frequency;
        logic [NET_W-1:0]  network;
    } nft_entry_t;

    // result of the shared distance comparator
    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] delta;
    } nft_cmp_t;

endpackage

### rtl/nft_dist_unit.sv
// ----------------------------------------------------------------------------
// nft_dist_unit
// Shared absolute-distance comparator: |a - b| < limit.
// ----------------------------------------------------------------------------
module nft_dist_unit (
    input  logic [nft_pkg::FREQ_W-1:0] slot_freq,
    input  logic [nft_pkg::FREQ_W-1:0] key_freq,
    input  logic [nft_pkg::DIST_W-1:0] limit,
    output nft_pkg::nft_cmp_t          cmp
);
    import nft_pkg::*;

    logic [FREQ_W-1:0] diff;

    always_comb
    begin
        if (slot_freq > key_freq)
        begin
            diff = slot_freq - key_freq;
        end
        else
        begin
            diff = key_freq - slot_freq;
        end
        cmp.hit   = diff < {{(FREQ_W-DIST_W){1'b0}}, limit};
        // only meaningful on a hit, where it fits
        cmp.delta = diff[DIST_W-1:0];
    end

endmodule

### rtl/nft_slot_mem.sv
// ----------------------------------------------------------------------------
// nft_slot_mem
// Slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nft_slot_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  nft_pkg::nft_entry_t      wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output nft_pkg::nft_entry_t      rd_data
);
    import nft_pkg::*;

    nft_entry_t mem [DEPTH];
    nft_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/nearest_frequency_tuning_table.sv
// ----------------------------------------------------------------------------
// nearest_frequency_tuning_table
// Per-antenna table of tuner network words, searched by nearest frequency.
// ----------------------------------------------------------------------------
// A store or an enabled lookup holds busy through SCAN, DRAIN and COMMIT;
//   done pulses in the cycle busy drops.
// A new command is taken only while idle; the scan makes one slot read
//   per cycle through the single memory read port and the shared comparator.
// A disabled lookup is taken without raising busy and gives no item.
// Reset: valid bits clear at once (no clearing pass), control regs take defaults.
// done is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_frequency_tuning_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  nft_pkg::nft_req_t             request,
    // result channel
    output logic                          done,
    output nft_pkg::nft_rsp_t             result,
    // configuration
    input  logic                          cfg_we,
    input  logic [nft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nft_pkg::WIN_W-1:0]     cfg_data
);
    import nft_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Sequencer: SCAN reads one slot per cycle, the comparator works on the
    // registered read data in the following cycle; DRAIN handles the final slot and
    // COMMIT writes the table and issues the result.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } state_t;

    state_t               state_reg;
    logic [WIN_W-1:0]     match_window_reg;
    logic                 lookup_enable_reg;
    logic [TABLE_DEPTH-1:0] slot_valid_reg;
    logic [TABLE_DEPTH-1:0] clr_mask_reg;   // same-antenna slots within window
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [IDX_W-1:0]     p_idx_reg;        // slot whose data is on rd_data
    logic                 p_vld_reg;
    logic                 exact_reg;        // store: exact match seen
    logic                 free_reg;         // store: free slot seen
    logic                 found_reg;        // lookup: candidate within window
    logic                 done_reg;
    nft_rsp_t             result_reg;

    // payload registers, no reset
    nft_req_t             key_reg;
    logic [DIST_W-1:0]    best_reg;
    logic [NET_W-1:0]     best_net_reg;
    logic [IDX_W-1:0]     exact_idx_reg;
    logic [IDX_W-1:0]     free_idx_reg;

    nft_entry_t           rd_data;
    nft_entry_t           wr_data;
    nft_cmp_t             cmp;
    logic [DIST_W-1:0]    limit;
    logic [DIST_W-1:0]    window_limit;
    logic                 slot_match;
    logic                 is_store;
    logic                 store_ok;
    logic [IDX_W-1:0]     target;
    logic                 mem_we;
    logic                 accept;

    assign accept       = start && (state_reg == S_IDLE);
    assign is_store     = (key_reg.command == CMD_STORE);
    assign window_limit = {1'b0, match_window_reg} + DIST_W'(1);
    // store: d <= window; lookup: strictly better than the best so far
    assign limit        = is_store ? window_limit : best_reg;
    assign slot_match   = slot_valid_reg[p_idx_reg] && (rd_data.antenna == key_reg.antenna);
    assign store_ok     = exact_reg || free_reg;
    assign target       = exact_reg ? exact_idx_reg : free_idx_reg;
    assign mem_we       = (state_reg == S_COMMIT) && is_store && store_ok;

    assign wr_data.antenna   = key_reg.antenna;
    assign wr_data.frequency = key_reg.frequency;
    assign wr_data.network   = key_reg.network_in;

    nft_slot_mem #(
        .DEPTH(TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (target),
        .wr_data (wr_data),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    nft_dist_unit u_dist (
        .slot_freq (rd_data.frequency),
        .key_freq  (key_reg.frequency),
        .limit     (limit),
        .cmp       (cmp)
    );

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            match_window_reg  <= DEFAULT_WINDOW;
            lookup_enable_reg <= 1'b1;
            slot_valid_reg    <= '0;
            clr_mask_reg      <= '0;
            rd_idx_reg        <= '0;
            p_idx_reg         <= '0;
            p_vld_reg         <= 1'b0;
            exact_reg         <= 1'b0;
            free_reg          <= 1'b0;
            found_reg         <= 1'b0;
            done_reg          <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MATCH_WINDOW:  match_window_reg  <= cfg_data;
                    CFG_LOOKUP_ENABLE: lookup_enable_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            // slot evaluation, in the cycle after the read
            if (p_vld_reg)
            begin
                if (is_store)
                begin
                    if (slot_match && (rd_data.frequency == key_reg.frequency) && !exact_reg)
                    begin
                        exact_reg <= 1'b1;
                    end
                    if (!slot_valid_reg[p_idx_reg] && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                    if (slot_match && cmp.hit)
                    begin
                        clr_mask_reg[p_idx_reg] <= 1'b1;
                    end
                end
                else if (slot_match && cmp.hit)
                begin
                    found_reg <= 1'b1;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    p_vld_reg <= 1'b0;
                    if (accept && (request.command == CMD_STORE || lookup_enable_reg))
                    begin
                        state_reg    <= S_SCAN;
                        rd_idx_reg   <= '0;
                        clr_mask_reg <= '0;
                        exact_reg    <= 1'b0;
                        free_reg     <= 1'b0;
                        found_reg    <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    p_vld_reg <= 1'b1;
                    p_idx_reg <= rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    p_vld_reg <= 1'b0;
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    if (is_store)
                    begin
                        if (store_ok)
                        begin
                            for (int i = 0; i < TABLE_DEPTH; i++)
                            begin
                                if (IDX_W'(i) == target)
                                begin
                                    slot_valid_reg[i] <= 1'b1;
                                end
                                else if (clr_mask_reg[i])
                                begin
                                    slot_valid_reg[i] <= 1'b0;
                                end
                            end
                            result_reg.found       <= 1'b1;
                            result_reg.network_out <= key_reg.network_in;
                            result_reg.table_full  <= 1'b0;
                        end
                        else
                        begin
                            result_reg.found       <= 1'b0;
                            result_reg.network_out <= '0;
                            result_reg.table_full  <= 1'b1;
                        end
                    end
                    else
                    begin
                        result_reg.found       <= found_reg;
                        result_reg.network_out <= found_reg ? best_net_reg : '0;
                        result_reg.table_full  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= request;
            best_reg <= window_limit;
        end
        if (p_vld_reg)
        begin
            if (is_store)
            begin
                if (slot_match && (rd_data.frequency == key_reg.frequency) && !exact_reg)
                begin
                    exact_idx_reg <= p_idx_reg;
                end
                if (!slot_valid_reg[p_idx_reg] && !free_reg)
                begin
                    free_idx_reg <= p_idx_reg;
                end
            end
            else if (slot_match && cmp.hit)
            begin
                best_reg     <= cmp.delta;
                best_net_reg <= rd_data.network;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLK(a_done_idle, done |-> !busy, "result strobe while busy")
    `ASSERT_CLK(a_fell_done, $fell(busy) |-> done, "command ended without a result")
    `ASSERT_CLK(a_start_busy, start && !busy && (request.command == CMD_STORE || lookup_enable_reg) |=> busy, "command not started")
    `ASSERT_NEVER(a_full_found, done && result.table_full && result.found, "full and found together")
    `ASSERT_NEVER(a_zero_net, done && !result.found && (result.network_out != '0), "network word without a match")

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-frequency tuning table. A short
// hand-written list of commands and register writes comes first. Phases of
// random commands follow, each under its own window, enable and idle mix.
// Every command accepted by the block runs through a shadow copy of the
// table here. The expected reply is queued and compared field by field with
// each done strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import nft_pkg::*;

    localparam int DEPTH          = 64;
    localparam int SETTLE_CYCLES  = DEPTH + 8;   // one full scan plus margin
    localparam int WATCHDOG_LIMIT = 2000;        // cycles with no handshake at all

    // spare register indexes; writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    nft_req_t             request;
    logic                 done;
    nft_rsp_t             result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIN_W-1:0]     cfg_data;

    nearest_frequency_tuning_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Shadow of the tuning table and its registers
    // ------------------------------------------------------------------------
    logic              shadow_valid [DEPTH];
    logic [ANT_W-1:0]  shadow_ant   [DEPTH];
    logic [FREQ_W-1:0] shadow_freq  [DEPTH];
    logic [NET_W-1:0]  shadow_net   [DEPTH];
    logic [WIN_W-1:0]  shadow_window;
    logic              shadow_enable;

    nft_rsp_t tuner_replies_due [$];
    int       fail_count;

    // Reply pinned by hand for the current command (directed rows only).
    bit       pin_valid;
    nft_rsp_t pin_reply;

    // Centers around which random frequencies cluster, so lookups land near
    // stored entries instead of missing every time.
    logic [FREQ_W-1:0] freq_centers [8];

    // Runs one command through the shadow table. Returns 1 when the block
    // owes a reply, with that reply in rsp.
    function automatic bit predict_tuner_reply(input nft_req_t rq, output nft_rsp_t rsp);
        logic [31:0] best;
        logic [31:0] gap;
        int          hit;
        int          slot;
        begin
            rsp = '0;
            if (rq.command == CMD_LOOKUP)
            begin
                // disabled tuner: command swallowed, no reply, table untouched
                if (!shadow_enable)
                    return 1'b0;
                // strict less-than keeps the lowest slot on a tie; starting at
                // window + 1 means anything farther never counts
                best = 32'(shadow_window) + 32'd1;
                hit  = -1;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (shadow_valid[i] && shadow_ant[i] == rq.antenna)
                    begin
                        gap = (shadow_freq[i] > rq.frequency) ?
                              32'(shadow_freq[i] - rq.frequency) :
                              32'(rq.frequency - shadow_freq[i]);
                        if (gap < best)
                        begin
                            best = gap;
                            hit  = i;
                        end
                    end
                end
                if (hit >= 0)
                begin
                    rsp.found       = 1'b1;
                    rsp.network_out = shadow_net[hit];
                end
                return 1'b1;
            end

            // store: exact antenna/frequency match first, else lowest free slot
            slot = -1;
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (shadow_valid[i] && shadow_ant[i] == rq.antenna &&
                    shadow_freq[i] == rq.frequency)
                    slot = i;
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (!shadow_valid[i])
                    slot = i;
            if (slot < 0)
            begin
                // full table: store dropped, nothing evicted
                rsp.table_full = 1'b1;
                return 1'b1;
            end
            shadow_valid[slot] = 1'b1;
            shadow_ant[slot]   = rq.antenna;
            shadow_freq[slot]  = rq.frequency;
            shadow_net[slot]   = rq.network_in;
            // evict neighbors of the same antenna inside the window
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i != slot && shadow_valid[i] && shadow_ant[i] == rq.antenna)
                begin
                    gap = (shadow_freq[i] > rq.frequency) ?
                          32'(shadow_freq[i] - rq.frequency) :
                          32'(rq.frequency - shadow_freq[i]);
                    if (gap <= 32'(shadow_window))
                        shadow_valid[i] = 1'b0;
                end
            end
            rsp.found       = 1'b1;
            rsp.network_out = rq.network_in;
            return 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge, so the values seen are
    // the ones the block itself sees at that edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        nft_rsp_t due;
        nft_rsp_t calc;
        bit       owed;
        if (rst_n)
        begin
            // compare before predicting: a reply and a new command can share
            // an edge, and the reply belongs to the older command
            if (done)
            begin
                if (tuner_replies_due.size() == 0)
                begin
                    $error("reply with no command pending: found %0b network_out %h full %0b",
                           result.found, result.network_out, result.table_full);
                    fail_count++;
                end
                else
                begin
                    due = tuner_replies_due.pop_front();
                    if (result.found !== due.found)
                    begin
                        $error("found: expected %0b, got %0b", due.found, result.found);
                        fail_count++;
                    end
                    if (result.network_out !== due.network_out)
                    begin
                        $error("network_out: expected %h, got %h",
                               due.network_out, result.network_out);
                        fail_count++;
                    end
                    if (result.table_full !== due.table_full)
                    begin
                        $error("table_full: expected %0b, got %0b",
                               due.table_full, result.table_full);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                owed = predict_tuner_reply(request, calc);
                if (owed)
                    tuner_replies_due.push_back(pin_valid ? pin_reply : calc);
            end
            if (cfg_we)
            begin
                // spare indexes fall through untouched
                if (cfg_index == CFG_MATCH_WINDOW)
                    shadow_window = cfg_data;
                else if (cfg_index == CFG_LOOKUP_ENABLE)
                    shadow_enable = cfg_data[0];
            end
        end
    end

    // Watchdog: any handshake resets the count; a long silence ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver side. All inputs change at the falling edge; each task is entered
    // and left at a falling edge.
    // ------------------------------------------------------------------------

    // Holds start high until the block takes the item. start is left high on
    // return, so back-to-back items never drop it within one step.
    task automatic send_command(input nft_req_t rq, input int idle_cycles,
                                input bit pinned, input nft_rsp_t pinned_rsp);
        begin
            if (idle_cycles > 0)
            begin
                start = 1'b0;
                repeat (idle_cycles) @(negedge clk);
            end
            start     = 1'b1;
            request   = rq;
            pin_valid = pinned;
            pin_reply = pinned_rsp;
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
        end
    endtask

    // Quiet point: all replies in, then start held low for a full scan's worth
    // of cycles and a margin.
    task automatic drain;
        begin
            start = 1'b0;
            while (tuner_replies_due.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
        begin
            drain();
            cfg_we    = 1'b1;
            cfg_index = idx;
            cfg_data  = value;
            @(negedge clk);
            cfg_we    = 1'b0;
        end
    endtask

    // Random frequency: mostly clustered near the centers (or on a coarse grid
    // when filling the table), sometimes at the extremes or fully random.
    function automatic logic [FREQ_W-1:0] pick_frequency(input bit grid,
                                                         input logic [WIN_W-1:0] win);
        int          roll;
        logic [31:0] spread;
        logic [31:0] step;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return 30'd1000000000;
                    default: return '1;
                endcase
            end
            if (roll < 12)
                return FREQ_W'($urandom());
            if (grid)
            begin
                // grid points three windows apart: stores rarely evict, so the
                // table fills; jitter inside one window keeps lookups hitting
                step = 32'd3 * (32'(win) + 32'd1);
                return FREQ_W'(32'd5000000 + 32'($urandom_range(0, 127)) * step +
                               32'($urandom_range(0, 32'(win))));
            end
            spread = 32'(win) + 32'd4;
            return freq_centers[$urandom_range(0, 7)] +
                   FREQ_W'($urandom_range(0, 2 * spread)) - FREQ_W'(spread);
        end
    endfunction

    // One random phase: program window and enable, then issue commands until
    // replies_wanted of them owe a reply (swallowed lookups do not count).
    task automatic run_phase(input logic [WIN_W-1:0] win, input logic en,
                             input int idle_pct, input int store_pct,
                             input bit grid, input int replies_wanted);
        nft_req_t rq;
        int       counted;
        int       idle_cycles;
        begin
            write_reg(CFG_MATCH_WINDOW, win);
            write_reg(CFG_LOOKUP_ENABLE, WIN_W'(en));
            write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, WIN_W'($urandom()));
            freq_centers[0] = FREQ_W'($urandom_range(0, 50));
            freq_centers[1] = '1 - FREQ_W'($urandom_range(0, 50));
            for (int i = 2; i < 8; i++)
                freq_centers[i] = FREQ_W'($urandom());
            counted = 0;
            while (counted < replies_wanted)
            begin
                rq.command    = ($urandom_range(0, 99) < store_pct) ? CMD_STORE : CMD_LOOKUP;
                rq.antenna    = ($urandom_range(0, 4) == 0) ? ANT_W'($urandom_range(0, 15)) :
                                                              ANT_W'($urandom_range(0, 3));
                rq.frequency  = pick_frequency(grid, win);
                rq.network_in = $urandom();
                // long gaps too, so the next start can land anywhere in a scan
                idle_cycles = ($urandom_range(0, 99) < idle_pct) ?
                              $urandom_range(1, DEPTH + 4) : 0;
                send_command(rq, idle_cycles, 1'b0, '0);
                if (rq.command == CMD_STORE || en)
                    counted++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {
        ROW_PREDICTED,  // reply taken from the shadow table
        ROW_PINNED,     // reply typed in below
        ROW_REG         // register write
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        nft_req_t             rq;
        nft_rsp_t             rsp;
        logic [CFG_IDX_W-1:0] idx;
        logic [WIN_W-1:0]     value;
    } dir_row_t;

    dir_row_t directed_rows [$];

    function automatic void add_cmd(input row_kind_t kind, input logic cmd,
                                    input logic [ANT_W-1:0] ant,
                                    input logic [FREQ_W-1:0] freq,
                                    input logic [NET_W-1:0] net,
                                    input logic found = 1'b0,
                                    input logic [NET_W-1:0] net_out = '0,
                                    input logic full = 1'b0);
        dir_row_t row;
        begin
            row                    = '{kind: ROW_PREDICTED, default: '0};
            row.kind               = kind;
            row.rq.command         = cmd;
            row.rq.antenna         = ant;
            row.rq.frequency       = freq;
            row.rq.network_in      = net;
            row.rsp.found          = found;
            row.rsp.network_out    = net_out;
            row.rsp.table_full     = full;
            directed_rows.push_back(row);
        end
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WIN_W-1:0] value);
        dir_row_t row;
        begin
            row       = '{kind: ROW_REG, default: '0};
            row.kind  = ROW_REG;
            row.idx   = idx;
            row.value = value;
            directed_rows.push_back(row);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_MATCH_WINDOW;
        cfg_data   = '0;
        pin_valid  = 1'b0;
        pin_reply  = '0;
        fail_count = 0;
        shadow_window = DEFAULT_WINDOW;
        shadow_enable = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_ant[i]   = '0;
            shadow_freq[i]  = '0;
            shadow_net[i]   = '0;
        end

        // default window 25000, lookups enabled
        // empty table: lookup misses
        add_cmd(ROW_PINNED, CMD_LOOKUP, 4'd0, 30'd0, 32'd0, 1'b0, 32'd0, 1'b0);
        add_cmd(ROW_PINNED, CMD_STORE, 4'd0, 30'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        // exactly one window away still matches, one hertz more does not
        add_cmd(ROW_PINNED, CMD_LOOKUP, 4'd0, 30'd25000, 32'd0, 1'b1, 32'hFFFF_FFFF, 1'b0);
        add_cmd(ROW_PINNED, CMD_LOOKUP, 4'd0, 30'd25001, 32'd0, 1'b0, 32'd0, 1'b0);
        // all-ones frequency, past the stated range
        add_cmd(ROW_PINNED, CMD_STORE, 4'd15, 30'h3FFF_FFFF, 32'd0, 1'b1, 32'd0, 1'b0);
        add_cmd(ROW_PINNED, CMD_LOOKUP, 4'd15, 30'h3FFF_FFFF, 32'hDEAD_BEEF, 1'b1, 32'd0, 1'b0);
        // other antenna never matches
        add_cmd(ROW_PINNED, CMD_LOOKUP, 4'd1, 30'd0, 32'd0, 1'b0, 32'd0, 1'b0);
        // second store inside the window evicts the first
        add_cmd(ROW_PINNED, CMD_STORE, 4'd0, 30'd100000, 32'h1111_0001,
                1'b1, 32'h1111_0001, 1'b0);
        add_cmd(ROW_PINNED, CMD_STORE, 4'd0, 30'd110000, 32'h2222_0002,
                1'b1, 32'h2222_0002, 1'b0);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd0, 30'd100000, 32'd0);
        // exact match is overwritten in place
        add_cmd(ROW_PINNED, CMD_STORE, 4'd0, 30'd110000, 32'h3333_0003,
                1'b1, 32'h3333_0003, 1'b0);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd0, 30'd110000, 32'd0);
        // equal distance to two entries: lower slot wins
        add_cmd(ROW_PINNED, CMD_STORE, 4'd2, 30'd200000, 32'h4444_0004,
                1'b1, 32'h4444_0004, 1'b0);
        add_cmd(ROW_PINNED, CMD_STORE, 4'd2, 30'd250000, 32'h5555_0005,
                1'b1, 32'h5555_0005, 1'b0);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd2, 30'd225000, 32'd0);
        // zero window: exact hits only
        add_reg(CFG_MATCH_WINDOW, 20'd0);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd2, 30'd200001, 32'd0);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd2, 30'd250000, 32'd0);
        // widest window the register holds
        add_reg(CFG_MATCH_WINDOW, 20'hFFFFF);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd2, 30'd0, 32'd0);
        // spare indexes are ignored
        add_reg(CFG_SPARE_2, 20'd0);
        add_reg(CFG_SPARE_3, 20'hFFFFF);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd0, 30'd500000, 32'd0);
        // tuner disabled: lookup swallowed, store still works
        add_reg(CFG_LOOKUP_ENABLE, 20'd0);
        add_cmd(ROW_PREDICTED, CMD_LOOKUP, 4'd0, 30'd110000, 32'd0);
        add_cmd(ROW_PINNED, CMD_STORE, 4'd0, 30'd0, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 1'b0);
        add_reg(CFG_LOOKUP_ENABLE, 20'd1);
        add_reg(CFG_MATCH_WINDOW, DEFAULT_WINDOW);
        add_cmd(ROW_PINNED, CMD_LOOKUP, 4'd3, 30'd1000000000, 32'd0, 1'b0, 32'd0, 1'b0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            else
                send_command(directed_rows[i].rq, 0, directed_rows[i].kind == ROW_PINNED,
                             directed_rows[i].rsp);
        end

        // window, enable, sender idle %, store %, grid fill, replies
        run_phase(20'd25000,   1'b1, 0,  50, 1'b0, 300);
        run_phase(20'd0,       1'b1, 73, 50, 1'b0, 250);
        run_phase(20'hFFFFF,   1'b1, 10, 40, 1'b0, 250);
        run_phase(WIN_W'($urandom_range(0, 20'hFFFFF)), 1'b0, 10, 40, 1'b0, 60);
        // fill phase: mostly stores on a sparse grid, so the table fills up
        run_phase(20'd1000,    1'b1, 0,  85, 1'b1, 350);
        run_phase(20'd1000000, 1'b1, 73, 30, 1'b0, 300);

        drain();
        if (tuner_replies_due.size() != 0)
        begin
            $error("%0d replies never arrived", tuner_replies_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
